// ===== src/osu_pkg.sv =====
// Package for the operand stack unit: widths, operation and status codes,
// controller state type. No dependencies.
package osu_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int MODE_W          = 3;
    localparam int DROP_W          = 8;
    localparam int STATUS_W        = 2;

    localparam logic [DATA_W-1:0] ERR_VALUE = '1;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_ADD  = 3'd2,
        OP_DUP  = 3'd3,
        OP_IFEQ = 3'd4,
        OP_JUMP = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    // What to do with the word read back from the stack memory
    typedef enum logic [1:0] {
        PD_REFILL,
        PD_SUM,
        PD_TOP
    } t_pend;

endpackage

// ===== src/osu_cmd_if.sv =====
// Command channel of the operand stack unit: valid/ready plus operation fields.
// Depends on osu_pkg.
interface osu_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [osu_pkg::MODE_W-1:0]  mode;
    logic signed [osu_pkg::DATA_W-1:0] push_value;
    logic [osu_pkg::DROP_W-1:0]  drop_count;

    modport source (output valid, output mode, output push_value, output drop_count,
                    input ready);
    modport sink   (input valid, input mode, input push_value, input drop_count,
                    output ready);
endinterface

// ===== src/osu_res_if.sv =====
// Result channel of the operand stack unit: valid/ready plus value and status.
// Depends on osu_pkg.
interface osu_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [osu_pkg::DATA_W-1:0]   result_value;
    logic [osu_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== src/osu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port: data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/operand_stack_unit.sv =====
// Operand stack unit top level: controller, top-of-stack cache, result register.
// Depends on osu_pkg, osu_cmd_if, osu_res_if and osu_ram.
//
//  channel | port  | direction | fields
//  --------+-------+-----------+----------------------------------
//  command | i_cmd | in        | mode, push_value, drop_count
//  result  | o_res | out       | result_value, status
//
// Push, dup, error cases, ifeq on a zero top and drops that empty the stack
// finish in S_IDLE alone. Pop with entries left, add, and ifeq/jump that leave
// entries also pass through S_LOAD: the stack memory has one read port with
// registered read data, and the new top (or second operand) comes from it.
// Reset (synchronous, active low) empties the stack; memory contents are kept.
// A result that is not taken stalls the unit at the next item that returns one.
module operand_stack_unit #(
    parameter int STACK_DEPTH = osu_pkg::STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    osu_cmd_if.sink      i_cmd,
    osu_res_if.source    o_res
);
    import osu_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = (CW > DROP_W) ? CW : DROP_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DATA_W-1:0] r_top, n_top;
    logic [AW-1:0]     r_addr, n_addr;
    t_pend             r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    t_status           r_out_status, n_out_status;

    logic              w_slot;
    logic              w_accept;
    logic              w_go_load;
    logic              w_empty;
    logic              w_full;
    logic [CW-1:0]     w_drop_cnt;
    logic [DATA_W-1:0] w_sum;
    logic              w_emit;
    logic [DATA_W-1:0] w_emit_value;
    t_status           w_emit_status;

    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;

    osu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Handshake and stack conditions
    assign w_slot      = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_slot;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_empty     = (r_cnt == '0);
    assign w_full      = (r_cnt == CW'(STACK_DEPTH));
    assign w_drop_cnt  = (DW'(i_cmd.drop_count) >= DW'(r_cnt)) ? '0
                       : CW'(DW'(r_cnt) - DW'(i_cmd.drop_count));
    assign w_sum       = r_top + w_rd_data;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_go_load) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_pend == PD_REFILL || w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_cnt         = r_cnt;
        n_top         = r_top;
        n_addr        = r_addr;
        n_pend        = r_pend;
        w_go_load     = 1'b0;
        w_emit        = 1'b0;
        w_emit_value  = '0;
        w_emit_status = ST_OK;
        w_wr_en       = 1'b0;
        w_wr_addr     = AW'(r_cnt);
        w_wr_data     = r_top;
        w_rd_en       = 1'b0;
        w_rd_addr     = AW'(r_cnt - CW'(1));
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_emit = 1'b1;
                    case (t_op'(i_cmd.mode))
                        OP_PUSH: begin
                            if (w_full) begin
                                w_emit_value  = ERR_VALUE;
                                w_emit_status = ST_FULL;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_data = i_cmd.push_value;
                                n_top     = i_cmd.push_value;
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                w_emit_value  = ERR_VALUE;
                                w_emit_status = ST_EMPTY;
                            end else begin
                                w_emit_value = r_top;
                                n_cnt        = r_cnt - CW'(1);
                                // Refill the cached top from the entry below
                                if (r_cnt > CW'(1)) begin
                                    w_rd_en   = 1'b1;
                                    w_rd_addr = AW'(r_cnt - CW'(2));
                                    n_pend    = PD_REFILL;
                                    w_go_load = 1'b1;
                                end
                            end
                        end
                        OP_ADD: begin
                            if (r_cnt < CW'(2)) begin
                                w_emit_value  = ERR_VALUE;
                                w_emit_status = ST_EMPTY;
                            end else begin
                                // Fetch the second operand, finish in S_LOAD once the result slot is free
                                w_emit    = 1'b0;
                                w_rd_en   = 1'b1;
                                w_rd_addr = AW'(r_cnt - CW'(2));
                                n_addr    = AW'(r_cnt - CW'(2));
                                n_cnt     = r_cnt - CW'(1);
                                n_pend    = PD_SUM;
                                w_go_load = 1'b1;
                            end
                        end
                        OP_DUP: begin
                            if (w_empty) begin
                                w_emit_value  = ERR_VALUE;
                                w_emit_status = ST_EMPTY;
                            end else if (w_full) begin
                                w_emit_value  = ERR_VALUE;
                                w_emit_status = ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_cnt   = r_cnt + CW'(1);
                            end
                        end
                        OP_IFEQ, OP_JUMP: begin
                            if (w_empty) begin
                                w_emit_value  = ERR_VALUE;
                                w_emit_status = ST_EMPTY;
                            end else if (t_op'(i_cmd.mode) == OP_IFEQ && r_top == '0) begin
                                w_emit_value = '0;
                            end else begin
                                n_cnt = w_drop_cnt;
                                if (w_drop_cnt == '0) begin
                                    w_emit_value = (t_op'(i_cmd.mode) == OP_IFEQ)
                                                 ? DATA_W'(1) : '0;
                                end else begin
                                    w_emit    = 1'b0;
                                    w_rd_en   = 1'b1;
                                    w_rd_addr = AW'(w_drop_cnt - CW'(1));
                                    n_pend    = PD_TOP;
                                    w_go_load = 1'b1;
                                end
                            end
                        end
                        default: begin
                            w_emit_value = '0;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                case (r_pend)
                    PD_REFILL: begin
                        n_top = w_rd_data;
                    end
                    PD_SUM: begin
                        // Write the sum back over the second operand
                        if (w_slot) begin
                            w_wr_en      = 1'b1;
                            w_wr_addr    = r_addr;
                            w_wr_data    = w_sum;
                            n_top        = w_sum;
                            w_emit       = 1'b1;
                            w_emit_value = w_sum;
                        end
                    end
                    PD_TOP: begin
                        if (w_slot) begin
                            n_top        = w_rd_data;
                            w_emit       = 1'b1;
                            w_emit_value = w_rd_data;
                        end
                    end
                    default: begin
                        n_top = w_rd_data;
                    end
                endcase
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // Result register: load on emit, drop when taken
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        if (w_emit) begin
            n_out_valid  = 1'b1;
            n_out_value  = w_emit_value;
            n_out_status = w_emit_status;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_addr       <= n_addr;
        r_pend       <= n_pend;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_value;
    assign o_res.status       = r_out_status;

endmodule
